// File: hdl/line_rect_pixel_rasterizer_assert.svh
// assertion macros for the line and rectangle rasterizer
// no dependencies
`ifndef LINE_RECT_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_RECT_PIXEL_RASTERIZER_ASSERT_SVH
// property that must hold every cycle out of reset
`define LRR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("lrr check");
// implication whose consequent is checked in the next cycle
`define LRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrr check");
`endif

// File: hdl/lrr_pkg.sv
// shared types and constants for the rasterizer
// no dependencies
package lrr_pkg;
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_POINT = 3'd1;
  localparam logic [2:0] CMD_MOVETO = 3'd2;
  localparam logic [2:0] CMD_LINE = 3'd3;
  localparam logic [2:0] CMD_LINETO = 3'd4;
  localparam logic [2:0] CMD_HOLLOW = 3'd5;
  localparam logic [2:0] CMD_SOLID = 3'd6;
  localparam logic [2:0] CMD_RSVD = 3'd7;

  localparam logic [2:0] OP_POINT = 3'd1;
  localparam logic [2:0] OP_XMAJOR = 3'd3;
  localparam logic [2:0] OP_YMAJOR = 3'd4;
  localparam logic [2:0] OP_HOLLOW = 3'd5;
  localparam logic [2:0] OP_SOLID = 3'd6;

  localparam int unsigned CFG_LINE_WIDTH = 0;
  localparam int unsigned CFG_DRAW_COLOR = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIXEL,
    ST_INDEX,
    ST_OUT
  } lrr_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;    // load shape from command
    logic pixel;    // compute current pixel and advance
    logic index;    // form linear index
  } lrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic draws;    // latched command starts a drawing
  } lrr_stat_t;
endpackage

// File: hdl/lrr_datapath.sv
// datapath: shape registers, line stepper, index multiply
// depends on lrr_pkg
module lrr_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lrr_pkg::lrr_cmd_t       cmd,
  output lrr_pkg::lrr_stat_t      stat,
  input  logic                    in_fire,
  input  logic [2:0]              command,
  input  logic [COORD_BITS-1:0]   x_a,
  input  logic [COORD_BITS-1:0]   y_a,
  input  logic [COORD_BITS-1:0]   x_b,
  input  logic [COORD_BITS-1:0]   y_b,
  input  logic [12:0]             line_width,
  output logic [23:0]             pixel_index,
  output logic                    last_write
);
  import lrr_pkg::*;
  localparam int CB = COORD_BITS;

  logic [CB-1:0] pen_x, pen_y, low_x, low_y, high_x, high_y;
  logic [CB-1:0] cx, cy, px, py, xa, ya, xb, yb;
  logic [CB:0]   major_count, minor_count, line_quotient;
  logic [CB:0]   line_remainder;
  logic [1:0]    rect_phase;
  logic [2:0]    op_kind, lcmd;
  logic          last;

  // latch command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lcmd <= command; xa <= x_a; ya <= y_a; xb <= x_b; yb <= y_b;
    end
  end
  assign stat.draws = (lcmd != CMD_TICK) && (lcmd != CMD_MOVETO) && (lcmd != CMD_RSVD);

  // line setup values
  logic [CB-1:0] sx, sy;
  logic [CB-1:0] adx, ady;
  always_comb begin
    sx = (lcmd == CMD_LINETO) ? pen_x : xa;
    sy = (lcmd == CMD_LINETO) ? pen_y : ya;
    adx = (xb > sx) ? xb - sx : sx - xb;
    ady = (yb > sy) ? yb - sy : sy - yb;
  end

  // pixel step combinational
  logic [CB:0]   span, w, h, lim, off, rem_sum;
  logic [CB-1:0] minor, major;
  logic          xm, neg, tog, side;
  always_comb begin
    xm = (op_kind == OP_XMAJOR);
    neg = rect_phase[1];
    tog = rect_phase[0];
    side = rect_phase[1];
    w = {1'b0, high_x - low_x};
    h = {1'b0, high_y - low_y};
    span = xm ? w : h;
    off = line_quotient + {{CB{1'b0}}, (neg && line_remainder != '0)};
    minor = neg ? (xm ? low_y : low_x) - off[CB-1:0] : (xm ? low_y : low_x) + off[CB-1:0];
    major = (xm ? low_x : low_y) + major_count[CB-1:0];
    rem_sum = line_remainder + minor_count;
    lim = side ? h : w;
    cx = low_x; cy = low_y; last = 1'b1;
    case (op_kind)
      OP_XMAJOR, OP_YMAJOR: begin
        cx = xm ? major : minor;
        cy = xm ? minor : major;
        last = (major_count >= span);
      end
      OP_HOLLOW: begin
        cx = side ? (tog ? high_x : low_x) : low_x + major_count[CB-1:0];
        cy = side ? low_y + major_count[CB-1:0] : (tog ? high_y : low_y);
        last = tog && side && (major_count >= lim);
      end
      OP_SOLID: begin
        cx = low_x + major_count[CB-1:0];
        cy = tog ? high_y - minor_count[CB-1:0] : low_y + minor_count[CB-1:0];
        last = tog && (minor_count >= (h >> 1)) && (major_count >= w);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0; pen_y <= '0; op_kind <= '0;
    end else if (cmd.start) begin
      major_count <= '0;
      line_quotient <= '0; line_remainder <= '0;
      case (lcmd)
        CMD_POINT: begin
          op_kind <= OP_POINT;
          minor_count <= '0; rect_phase <= 2'd0;
          low_x <= xa; low_y <= ya; high_x <= xa; high_y <= ya;
          pen_x <= xa; pen_y <= ya;
        end
        CMD_LINE, CMD_LINETO: begin
          if (lcmd == CMD_LINETO) begin
            pen_x <= xb; pen_y <= yb;
          end
          if (adx > ady) begin
            op_kind <= OP_XMAJOR;
            minor_count <= {1'b0, ady};
            if (xb < sx) begin
              low_x <= xb; low_y <= yb; high_x <= sx; high_y <= sy;
              rect_phase <= (sy < yb) ? 2'd2 : 2'd0;
            end else begin
              low_x <= sx; low_y <= sy; high_x <= xb; high_y <= yb;
              rect_phase <= (yb < sy) ? 2'd2 : 2'd0;
            end
          end else begin
            op_kind <= OP_YMAJOR;
            minor_count <= {1'b0, adx};
            if (yb < sy) begin
              low_x <= xb; low_y <= yb; high_x <= sx; high_y <= sy;
              rect_phase <= (sx < xb) ? 2'd2 : 2'd0;
            end else begin
              low_x <= sx; low_y <= sy; high_x <= xb; high_y <= yb;
              rect_phase <= (xb < sx) ? 2'd2 : 2'd0;
            end
          end
        end
        CMD_HOLLOW, CMD_SOLID: begin
          op_kind <= (lcmd == CMD_HOLLOW) ? OP_HOLLOW : OP_SOLID;
          minor_count <= '0; rect_phase <= 2'd0;
          low_x <= (xa < xb) ? xa : xb; high_x <= (xa < xb) ? xb : xa;
          low_y <= (ya < yb) ? ya : yb; high_y <= (ya < yb) ? yb : ya;
        end
        CMD_MOVETO: begin
          pen_x <= xa; pen_y <= ya;
        end
        default: ;
      endcase
    end else if (cmd.pixel) begin
      px <= cx; py <= cy; last_write <= last;
      case (op_kind)
        OP_XMAJOR, OP_YMAJOR: if (!last) begin
          major_count <= major_count + 1'b1;
          if (rem_sum >= span) begin
            line_remainder <= rem_sum - span;
            line_quotient <= line_quotient + 1'b1;
          end else line_remainder <= rem_sum;
        end
        OP_HOLLOW: begin
          if (!tog) rect_phase[0] <= 1'b1;
          else if (major_count >= lim) begin
            if (!side) begin
              rect_phase <= 2'd2; major_count <= '0;
            end
          end else begin
            rect_phase[0] <= 1'b0; major_count <= major_count + 1'b1;
          end
        end
        OP_SOLID: begin
          rect_phase <= {1'b0, !tog};
          if (tog) begin
            if (minor_count >= (h >> 1)) begin
              if (!last) begin
                minor_count <= '0; major_count <= major_count + 1'b1;
              end
            end else minor_count <= minor_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // index: one multiply, registered
  logic [23:0] prod;
  always_comb prod = 24'({{(24-CB){1'b0}}, py} * {11'd0, line_width} + {{(24-CB){1'b0}}, px});
  always_ff @(posedge clk) begin
    if (cmd.index) pixel_index <= prod;
  end
  assign stat.last = last_write;
endmodule

// File: hdl/lrr_ctrl.sv
// controller state machine for the rasterizer
// depends on lrr_pkg
module lrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  lrr_pkg::lrr_stat_t  stat,
  output lrr_pkg::lrr_cmd_t   cmd,
  output logic                busy,
  output logic                in_ready,
  output logic                out_valid
);
  import lrr_pkg::*;
  lrr_state_t state, state_next;
  logic       started, started_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; started <= 1'b0;
    end else begin
      state <= state_next; started <= started_next;
    end
  end

  always_comb begin
    state_next = state; started_next = started;
    cmd = '0;
    in_ready = 1'b0; out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_next = ST_PIXEL;
      end
      ST_PIXEL: begin
        if (!started) begin
          cmd.start = 1'b1;
          if (stat.draws) started_next = 1'b1;
          else state_next = ST_IDLE;
        end else begin
          cmd.pixel = 1'b1;
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: begin
        cmd.index = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_next = ST_IDLE;
          if (stat.last) started_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
  assign busy = started;
endmodule

// File: hdl/line_rect_pixel_rasterizer.sv
// line and rectangle rasterizer top level
// depends on lrr_pkg, lrr_ctrl, lrr_datapath, assertion macro header
//
// usage:
//  - input channel (valid/ready) carries one command beat: tick, point, moveto,
//    line, lineto, hollow or solid rectangle with two coordinate pairs
//  - each accepted beat yields zero or one result beat on the output channel
//  - a drawing command loads the shape and gives its first pixel; every later
//    beat (tick or any command) gives the next pixel until last_write
//  - a drawing command or moveto arriving while a shape runs is dropped and
//    the result beat carries rejected along with the pixel
//  - tick or moveto while idle gives no result
//  - results are registered through the load (first pixel only), pixel step
//    and index multiply stages
//  - only one beat is in flight; input is not ready until the result is taken
//  - a stalled receiver holds the result; input stays not ready meanwhile
//  - configuration writes (line_width, draw_color) at any idle time;
//    color is sampled as the result is presented
//  - reset: line_width 800, color 0, pen at origin, no shape running
module line_rect_pixel_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid_in,
  output logic                  ready_in,
  input  logic [2:0]            command,
  input  logic [COORD_BITS-1:0] x_a,
  input  logic [COORD_BITS-1:0] y_a,
  input  logic [COORD_BITS-1:0] x_b,
  input  logic [COORD_BITS-1:0] y_b,
  output logic                  valid_out,
  input  logic                  ready_out,
  output logic                  write_valid,
  output logic [23:0]           pixel_index,
  output logic [31:0]           pixel_value,
  output logic                  last_write,
  output logic                  rejected,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);
  import lrr_pkg::*;
  `include "line_rect_pixel_rasterizer_assert.svh"

  logic [12:0] line_width;
  logic [31:0] draw_color;
  logic        in_fire, out_fire, busy, rej, lw;
  logic [23:0] idx;
  lrr_cmd_t    cmd;
  lrr_stat_t   stat;

  assign in_fire = valid_in && ready_in;
  assign out_fire = valid_out && ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 13'd800; draw_color <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_LINE_WIDTH)) line_width <= cfg_data[12:0];
      else draw_color <= cfg_data;
    end
  end

  // rejected flag: a drawing command or moveto taken while a shape is running
  always_ff @(posedge clk) begin
    if (in_fire) rej <= busy && (command >= CMD_POINT) && (command <= CMD_SOLID);
  end

  lrr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .stat, .cmd, .busy,
    .in_ready(ready_in), .out_valid(valid_out)
  );

  lrr_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .in_fire, .command, .x_a, .y_a, .x_b, .y_b,
    .line_width, .pixel_index(idx), .last_write(lw)
  );

  assign write_valid = 1'b1;
  assign pixel_index = idx;
  assign pixel_value = draw_color;
  assign last_write = lw;
  assign rejected = rej;

  `LRR_ASSERT_ALWAYS(a_no_overlap, !(ready_in && valid_out))
  `LRR_ASSERT_NEXT(a_hold, valid_out && !ready_out, valid_out && $stable(pixel_index))
  `LRR_ASSERT_NEXT(a_done, out_fire && last_write, !busy)
endmodule
